FILE: src/longest_distinct_char_window_unit_defines.svh
// Assertion macros shared by the longest distinct character window unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LONGEST_DISTINCT_CHAR_WINDOW_UNIT_DEFINES_SVH
`define LONGEST_DISTINCT_CHAR_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LDCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define LDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: src/ldcw_pkg.sv
// Types and constants for the longest distinct character window unit.
// No dependencies; imported by every module of the block except ldcw_ram.
package ldcw_pkg;

    // One input byte and its end-of-string mark
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    // One result
    typedef struct packed {
        logic [15:0] window_start;
        logic [15:0] window_length;
        logic [15:0] best_start;
        logic [15:0] best_length;
        logic        overflow;
    } result_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

endpackage

FILE: src/ldcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-byte last position table.
module ldcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read ports; a read of the same address in the same cycle sees old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ldcw_front.sv
// Front end: accepts bytes, folds out-of-alphabet codes, queues them.
// Depends on ldcw_pkg.
module ldcw_front #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  ldcw_pkg::item_t item,
    output logic           q_valid,
    input  logic           q_ready,
    output ldcw_pkg::item_t q_item
);

    import ldcw_pkg::*;

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    item_t                classified;
    logic                 push;
    logic                 pop;

    // Bytes beyond the alphabet map onto its last symbol
    always_comb
    begin
        classified = item;
        if (int'(item.ch) >= ALPHABET_SIZE)
        begin
            classified.ch = 8'(ALPHABET_SIZE - 1);
        end
    end

    assign item_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_item     = entry_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/ldcw_back.sv
// Back end: table lookup, window tracking and result register.
// Depends on ldcw_pkg, ldcw_ram and the shared assertion macros.
`include "longest_distinct_char_window_unit_defines.svh"

module ldcw_back #(
    parameter int POS_BITS      = 16,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  ldcw_pkg::item_t  q_item,
    output logic             result_valid,
    input  logic             result_ready,
    output ldcw_pkg::result_t result
);

    import ldcw_pkg::*;

    localparam int IDX_BITS = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    // String state
    logic [POS_BITS-1:0]      position_reg;
    logic [POS_BITS-1:0]      start_pos_reg;
    logic [POS_BITS-1:0]      best_start_reg;
    logic [POS_BITS-1:0]      best_length_reg;
    logic                     overflow_reg;
    logic [ALPHABET_SIZE-1:0] seen_reg;

    // Lookup stage
    logic                s2_valid_reg;
    item_t               s2_item_reg;
    logic                fwd_hit_reg;
    logic [POS_BITS-1:0] fwd_pos_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_data_reg;

    logic                s2_fire;
    logic                s2_load;
    logic                wr_en;
    logic [IDX_BITS-1:0] s2_idx;
    logic [IDX_BITS-1:0] head_idx;
    logic [POS_BITS-1:0] ram_rd_data;
    logic [POS_BITS-1:0] last_pos;
    logic                ovf_now;
    logic                repeat_hit;
    logic [POS_BITS-1:0] new_start;
    logic [POS_BITS-1:0] win_len;
    logic                better;
    logic [POS_BITS-1:0] best_start_next;
    logic [POS_BITS-1:0] best_length_next;
    result_t             out_data_next;

    assign s2_idx   = s2_item_reg.ch[IDX_BITS-1:0];
    assign head_idx = q_item.ch[IDX_BITS-1:0];

    // Stage handshakes
    assign s2_fire = s2_valid_reg && (!out_valid_reg || result_ready);
    assign q_ready = !s2_valid_reg || s2_fire;
    assign s2_load = q_valid && q_ready;

    // Last position table; read issued as an item enters the lookup stage
    ldcw_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (ALPHABET_SIZE)
    ) u_last_pos (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_idx),
        .wr_data (position_reg),
        .rd_en   (s2_load),
        .rd_addr (head_idx),
        .rd_data (ram_rd_data)
    );

    // Window update for the item in the lookup stage
    always_comb
    begin
        ovf_now    = overflow_reg || (position_reg == '1);
        wr_en      = s2_fire && !ovf_now;
        last_pos   = fwd_hit_reg ? fwd_pos_reg : ram_rd_data;
        repeat_hit = seen_reg[s2_idx] && (last_pos >= start_pos_reg);
        new_start  = repeat_hit ? (last_pos + POS_BITS'(1)) : start_pos_reg;
        win_len    = position_reg - new_start + POS_BITS'(1);
        better     = (win_len > best_length_reg);
        best_start_next  = better ? new_start : best_start_reg;
        best_length_next = better ? win_len : best_length_reg;

        if (ovf_now)
        begin
            out_data_next.window_start  = 16'(start_pos_reg);
            out_data_next.window_length = 16'(position_reg - start_pos_reg);
            out_data_next.best_start    = 16'(best_start_reg);
            out_data_next.best_length   = 16'(best_length_reg);
        end
        else
        begin
            out_data_next.window_start  = 16'(new_start);
            out_data_next.window_length = 16'(win_len);
            out_data_next.best_start    = 16'(best_start_next);
            out_data_next.best_length   = 16'(best_length_next);
        end
        out_data_next.overflow = ovf_now;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_item_reg <= q_item;
            fwd_pos_reg <= position_reg;
        end
        if (s2_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            position_reg    <= '0;
            start_pos_reg   <= '0;
            best_start_reg  <= '0;
            best_length_reg <= '0;
            overflow_reg    <= 1'b0;
            seen_reg        <= '0;
        end
        else
        begin
            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
                // table write this cycle is missed by the read of the same entry
                fwd_hit_reg  <= wr_en && (s2_idx == head_idx);
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end

            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                if (s2_item_reg.last)
                begin
                    position_reg    <= '0;
                    start_pos_reg   <= '0;
                    best_start_reg  <= '0;
                    best_length_reg <= '0;
                    overflow_reg    <= 1'b0;
                    seen_reg        <= '0;
                end
                else if (ovf_now)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    position_reg     <= position_reg + POS_BITS'(1);
                    start_pos_reg    <= new_start;
                    best_start_reg   <= best_start_next;
                    best_length_reg  <= best_length_next;
                    seen_reg[s2_idx] <= 1'b1;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Window never starts past the next position
    `LDCW_ASSERT_NOW(a_start_le_pos, clk, rst_n, 1'b1, start_pos_reg <= position_reg)
    // Best window is at least as long as the current one
    `LDCW_ASSERT_NOW(a_best_covers, clk, rst_n, 1'b1,
        best_length_reg >= POS_BITS'(position_reg - start_pos_reg))
    // Forwarding only applies to an occupied lookup stage
    `LDCW_ASSERT_NOW(a_fwd_valid, clk, rst_n, fwd_hit_reg, s2_valid_reg)
    // Overflow sticks until the end of the string
    `LDCW_ASSERT_NEXT(a_ovf_sticky, clk, rst_n,
        overflow_reg && !(s2_fire && s2_item_reg.last), overflow_reg)

endmodule

FILE: src/longest_distinct_char_window_unit.sv
// Top level of the longest distinct character window unit.
// Depends on ldcw_pkg, ldcw_front and ldcw_back.
//
// Takes one byte per transfer and returns one result per byte: the current
// window of distinct bytes and the earliest longest such window of the string.
// Sustained rate is one byte per clock while the result sink is ready; a byte
// passes through the queue and then the lookup stage, where the table is read,
// and its result then sits in the result register. The rate rests on the
// registered read port of the last-position table, whose update
// for one byte is forwarded to the read of the next. Seen flags clear
// together at a byte marked last, so there is no clearing pass after reset.
// Positions saturate at 2^POS_BITS-1 and set the overflow flag.
module longest_distinct_char_window_unit #(
    parameter int POS_BITS      = 16,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ldcw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ldcw_pkg::result_t result
);

    import ldcw_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // Accept, classify, queue
    ldcw_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    // Table lookup and window tracking
    ldcw_back #(
        .POS_BITS      (POS_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: tb/longest_distinct_char_window_unit_tb.sv
// Self-checking bench for longest_distinct_char_window_unit: random-gap driver, stalling
// sink, and a window tracker that predicts every result. Depends on ldcw_pkg and the RTL.
module longest_distinct_char_window_unit_tb;
    import ldcw_pkg::*;

    localparam int GAP_MAX   = 40;
    localparam int STALL_MAX = 40;
    // ~1.6k bytes, each at worst a full sender gap, a full sink stall and the
    // pass through the block, with a wide margin on top
    localparam longint LIMIT = 64'd2_000_000;

    typedef struct packed {
        item_t it;
        logic  drain_first;  // hold this byte until every result is back
        logic  back_to_back; // no gap after this byte
    } feed_t;

    typedef enum {TEXT_ANY, TEXT_FEW, TEXT_EDGE, TEXT_WALK} text_style_e;
    typedef enum {RDY_OPEN, RDY_CHOPPY, RDY_SLOW} rdy_mode_e;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    feed_t   feed_q[$];
    result_t windows_due[$];
    feed_t   next_feed;
    int      gap_left;
    logic    drained;
    int      mismatches = 0;
    longint  cycles = 0;

    rdy_mode_e ready_mode;
    int        mode_left;
    int        stall_left;

    // Window tracker state
    logic [255:0] seen_ch = '0;
    logic [15:0]  last_pos [256];
    logic [15:0]  str_pos = '0;
    logic [15:0]  win_start = '0;
    logic [15:0]  best_start_r = '0;
    logic [15:0]  best_len_r = '0;
    logic         ovf_seen = 1'b0;

    longest_distinct_char_window_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the window by one byte and return what the block should report
    function automatic result_t track_window(input item_t it);
        result_t     r;
        logic [15:0] run_len;
        if (ovf_seen || str_pos == 16'hFFFF)
        begin
            // positions exhausted: everything freezes until the string ends
            ovf_seen = 1'b1;
            run_len  = str_pos - win_start;
        end
        else
        begin
            // a repeat inside the window moves the start past the earlier copy
            if (seen_ch[it.ch] && last_pos[it.ch] >= win_start)
                win_start = last_pos[it.ch] + 16'd1;
            last_pos[it.ch] = str_pos;
            seen_ch[it.ch]  = 1'b1;
            run_len = str_pos - win_start + 16'd1;
            // only a strictly longer window replaces the earliest best
            if (run_len > best_len_r)
            begin
                best_len_r   = run_len;
                best_start_r = win_start;
            end
            str_pos = str_pos + 16'd1;
        end
        r.window_start  = win_start;
        r.window_length = run_len;
        r.best_start    = best_start_r;
        r.best_length   = best_len_r;
        r.overflow      = ovf_seen;
        if (it.last)
        begin
            seen_ch      = '0;
            str_pos      = '0;
            win_start    = '0;
            best_start_r = '0;
            best_len_r   = '0;
            ovf_seen     = 1'b0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, GAP_MAX);
    endfunction

    task automatic add_byte(input logic [7:0] c, input logic fin, input logic drain,
                            input logic b2b);
        feed_t f;
        f.it.ch        = c;
        f.it.last      = fin;
        f.drain_first  = drain;
        f.back_to_back = b2b;
        feed_q.insert(feed_q.size(), f);
    endtask

    task automatic add_word(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], i == s.len() - 1, 1'b0, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 30)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Driver: presents queued bytes, holds each until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   <= 0;
        end
        else if (!item_valid || item_ready)
        begin
            if (gap_left != 0)
            begin
                item_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (feed_q.size() != 0 &&
                     (!feed_q[0].drain_first || (drained && !(item_valid && item_ready))))
            begin
                next_feed = feed_q.pop_front();
                item_valid <= 1'b1;
                item       <= next_feed.it;
                gap_left   <= next_feed.back_to_back ? 0 : pick_gap();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Sink: alternates open, choppy and slow stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_mode   <= RDY_OPEN;
            mode_left    <= 0;
            stall_left   <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= rdy_mode_e'($urandom_range(0, 2));
                mode_left  <= $urandom_range(50, 500);
            end
            else
                mode_left <= mode_left - 1;

            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (ready_mode == RDY_CHOPPY && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end
            else if (ready_mode == RDY_SLOW && $urandom_range(0, 31) == 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= $urandom_range(9, STALL_MAX - 1);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each byte transfer, checks each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drained <= 1'b1;
        else
        begin
            if (item_valid && item_ready)
                windows_due.insert(windows_due.size(), track_window(item));
            if (result_valid && result_ready)
            begin
                if (windows_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 30)
                        $error("result transfer with no byte outstanding");
                end
                else
                begin
                    check_field("window_start", windows_due[0].window_start,
                                result.window_start);
                    check_field("window_length", windows_due[0].window_length,
                                result.window_length);
                    check_field("best_start", windows_due[0].best_start, result.best_start);
                    check_field("best_length", windows_due[0].best_length,
                                result.best_length);
                    check_field("overflow", {15'd0, windows_due[0].overflow},
                                {15'd0, result.overflow});
                    void'(windows_due.pop_front());
                end
            end
            drained <= (windows_due.size() == 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("longest_distinct_char_window_unit: mismatch");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int          n;
        int          len;
        int          roll;
        logic [7:0]  c;
        logic [7:0]  base;
        logic [7:0]  step;
        logic        hold;
        logic        fast;
        text_style_e style;

        // Directed: lone extremes, classic repeat patterns, equal-length
        // windows that must not displace the earliest best, stale repeats
        add_byte(8'h00, 1'b1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0, 1'b0);
        add_word("abcabcbb");
        add_word("pwwkew");
        add_word("abba");
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0, 1'b0);

        // One string that starts only once the directed results are all back,
        // then runs with no gaps, repeating a seven-byte pattern
        for (int i = 0; i < 40; i++)
            add_byte(8'((i % 7) * 37), i == 39, i == 0, 1'b1);

        // Random strings of assorted length and content
        n = 0;
        while (n < 1470)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                len = $urandom_range(1, 24);
            else if (roll < 95)
                len = $urandom_range(25, 120);
            else
                len = $urandom_range(121, 400);
            style = text_style_e'($urandom_range(0, 3));
            base  = 8'($urandom_range(0, 255));
            step  = {7'($urandom_range(0, 127)), 1'b1};
            hold  = ($urandom_range(0, 19) == 0);
            fast  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++)
            begin
                case (style)
                    TEXT_ANY:  c = 8'($urandom_range(0, 255));
                    TEXT_FEW:  c = 8'(base + $urandom_range(0, 3));
                    TEXT_EDGE:
                        case ($urandom_range(0, 5))
                            0: c = 8'h00;
                            1: c = 8'hFF;
                            2: c = 8'h01;
                            3: c = 8'hFE;
                            4: c = 8'h80;
                            default: c = 8'h7F;
                        endcase
                    default:   c = 8'(base + k * step);
                endcase
                add_byte(c, k == len - 1, hold && k == 0, fast);
            end
            n += len;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || item_valid || windows_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatches == 0 && windows_due.size() == 0)
            $display("longest_distinct_char_window_unit: match");
        else
            $display("longest_distinct_char_window_unit: mismatch");
        $finish;
    end
endmodule
